/* hw/rtl/hdr_tonemap_gamma_encode_core_macros.svh */
// Assertion macros shared by the tone mapper RTL files.
`ifndef HDR_TONEMAP_GAMMA_ENCODE_CORE_MACROS_SVH
`define HDR_TONEMAP_GAMMA_ENCODE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HDRTM_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define HDRTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HDRTM_ASSERT(label, clk, rst, cond, msg)
`define HDRTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/hdrtm_pkg.sv */
// Shared constants, types and elaboration-time functions of the tone mapper.
`timescale 1ns / 1ps
package hdrtm_pkg;

  localparam int GAMMA_TABLE_DEPTH = 4096;
  localparam int CH_W     = 24;
  localparam int BYTE_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LOG_W    = 24;
  localparam int NROOTS   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TONE_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_VALUE   = 2'd2;

  localparam logic              RST_TONE_ENABLE   = 1'b1;
  localparam logic [GAIN_W-1:0] RST_EXPOSURE_GAIN = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_GAMMA_VALUE   = 16'd9011;

  // Filmic curve coefficients in Q.16.
  localparam int K_A_MUL = 164495;
  localparam int K_A_ADD = 1966;
  localparam int K_B_MUL = 159252;
  localparam int K_B_ADD = 38666;
  localparam int K_D_ADD = 9175;

  typedef logic [30:0] root_arr_t [NROOTS];

  typedef struct packed {
    logic             pos;
    logic [22:0]      p;
    logic [2:0][22:0] c;
    logic [2:0][7:0]  raw;
  } ctx_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    n   = n_in;
    res = '0;
    bv  = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (bv > n) bv = bv >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bv != 0) begin
        if (n >= res + bv) begin
          n   = n - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [LOG_W-1:0] log2_q20(input logic [31:0] v);
    logic [4:0]  msb;
    logic [63:0] x;
    logic [19:0] frac;
    msb  = '0;
    frac = '0;
    for (int s = 0; s < 32; s++) begin
      if (v[s]) msb = 5'(s);
    end
    x = {32'd0, v} << (5'd30 - msb);
    for (int k = 1; k <= 20; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac[20-k] = 1'b1;
      end
    end
    return {msb[3:0], frac};
  endfunction

  function automatic root_arr_t make_roots();
    root_arr_t   r;
    logic [63:0] prev;
    prev = isqrt64(64'd1 << 59);
    r[0] = prev[30:0];
    for (int k = 1; k < NROOTS; k++) begin
      prev = isqrt64(prev << 30);
      r[k] = prev[30:0];
    end
    return r;
  endfunction

  localparam root_arr_t ROOTS = make_roots();

endpackage

/* hw/rtl/hdrtm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hdrtm_ram #(
  parameter int WIDTH = hdrtm_pkg::BYTE_W,
  parameter int DEPTH = hdrtm_pkg::GAMMA_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/hdrtm_curve_build.sv */
// Sequencer that computes the gamma encoding table one entry at a time.
`timescale 1ns / 1ps
`include "hdr_tonemap_gamma_encode_core_macros.svh"
module hdrtm_curve_build #(
  parameter int DEPTH = hdrtm_pkg::GAMMA_TABLE_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic [hdrtm_pkg::GAIN_W-1:0] gamma,
  output logic                        busy,
  output logic                        tbl_we,
  output logic [AW-1:0]               tbl_addr,
  output logic [hdrtm_pkg::BYTE_W-1:0] tbl_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_NORM  = 3'd1;
  localparam logic [2:0] ST_LOG   = 3'd2;
  localparam logic [2:0] ST_DPREP = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EXP   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [hdrtm_pkg::LOG_W-1:0] TOP_LOG = hdrtm_pkg::log2_q20(32'(DEPTH - 1));

  logic [2:0]    state;
  logic [AW-1:0] idx;
  logic [5:0]    cnt;
  logic [3:0]    msb;
  logic [30:0]   x;
  logic [19:0]   frac;
  logic [15:0]   rem;
  logic [36:0]   dvd;
  logic [30:0]   y;

  logic [15:0] g_eff;
  logic [3:0]  msb_c;
  logic [30:0] x_norm;
  logic [61:0] sq;
  logic [31:0] sq_sh;
  logic [23:0] d;
  logic [36:0] dvd_init;
  logic [16:0] rem2;
  logic        q_bit;
  logic [16:0] rem_sub;
  logic [61:0] ymul;
  logic [30:0] yshift;
  logic [39:0] ebig;
  logic [9:0]  e_full;
  logic [7:0]  e_byte;
  logic        exp_done_ok;

  always_comb begin
    g_eff = (gamma == '0) ? 16'd1 : gamma;
    msb_c = '0;
    for (int s = 0; s < AW; s++) begin
      if (idx[s]) msb_c = 4'(s);
    end
    x_norm   = 31'(idx) << (5'd30 - {1'b0, msb_c});
    sq       = {31'd0, x} * {31'd0, x};
    sq_sh    = sq[61:30];
    d        = TOP_LOG - {msb, frac};
    dvd_init = {1'b0, d, 12'd0} + 37'(g_eff >> 1);
    rem2     = {rem, dvd[36]};
    q_bit    = rem2 >= {1'b0, g_eff};
    rem_sub  = rem2 - {1'b0, g_eff};
    ymul     = {31'd0, y} * {31'd0, hdrtm_pkg::ROOTS[cnt[4:0]]} + (62'd1 << 29);
    yshift   = (dvd[36:20] >= 17'd31) ? '0 : (y >> dvd[24:20]);
    ebig     = {9'd0, yshift} * 40'd255 + (40'd1 << 29);
    e_full   = ebig[39:30];
    e_byte   = (e_full > 10'd255) ? 8'd255 : e_full[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= ST_NORM;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
        end
        ST_NORM: begin
          if (idx == '0) begin
            idx <= AW'(1);
          end else begin
            x     <= x_norm;
            msb   <= msb_c;
            frac  <= '0;
            cnt   <= '0;
            state <= ST_LOG;
          end
        end
        ST_LOG: begin
          x    <= sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
          frac <= {frac[18:0], sq_sh[31]};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd19) state <= ST_DPREP;
        end
        ST_DPREP: begin
          dvd   <= dvd_init;
          rem   <= '0;
          y     <= 31'd1 << 30;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          dvd <= {dvd[35:0], q_bit};
          rem <= q_bit ? rem_sub[15:0] : rem2[15:0];
          cnt <= cnt + 6'd1;
          if (cnt == 6'd36) begin
            cnt   <= '0;
            state <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (dvd[19]) y <= ymul[60:30];
          dvd[19:0] <= {dvd[18:0], 1'b0};
          cnt       <= cnt + 6'd1;
          if (cnt == 6'd19) state <= ST_FIN;
        end
        ST_FIN: begin
          if (idx == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            state <= ST_NORM;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy     = (state != ST_IDLE);
  assign tbl_we   = (state == ST_FIN) || ((state == ST_NORM) && (idx == '0));
  assign tbl_addr = idx;
  assign tbl_data = (state == ST_FIN) ? e_byte : '0;

  assign exp_done_ok = (state != ST_FIN) || (dvd[19:0] == '0);

  // After twenty exponent steps every fraction bit of the exponent has been consumed.
  `HDRTM_ASSERT(a_exp_bits_used, clk, rst, exp_done_ok, "exponent fraction not consumed")
  // The table is only written during a pass.
  `HDRTM_ASSERT(a_we_in_pass, clk, rst, !tbl_we || busy, "table write outside a pass")
  // The divider remainder stays below the gamma code.
  `HDRTM_ASSERT(a_div_rem, clk, rst, (state != ST_DIV) || (rem < g_eff), "divider remainder too large")

endmodule

/* hw/rtl/hdr_tonemap_gamma_encode_core.sv */
// Top level of the HDR tone mapper and gamma encoder pixel pipeline.
//
// Usage: a request carries one HDR pixel as three signed Q8.16 channels on
// red_in, green_in and blue_in. It is taken at a rising edge where start is
// high and busy is low. The block accepts one request every clock cycle
// while busy is low. Each result is shown on red_out, green_out and blue_out
// for exactly one cycle with done high, in request order. The receiver
// cannot stall, so the pipeline never holds.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data: index 0 tone_enable, 1 exposure_gain, 2 gamma_value; other
// indexes are ignored. The user must change configuration only while no
// pixel is in flight; the block itself does not enforce this.
// The gamma table is computed by a sequencer one entry at a time (log,
// divide and exponent steps). This pass runs after reset and after every
// gamma_value write; busy stays high and no request is taken meanwhile.
`timescale 1ns / 1ps
`include "hdr_tonemap_gamma_encode_core_macros.svh"
module hdr_tonemap_gamma_encode_core #(
  parameter int GAMMA_TABLE_DEPTH = hdrtm_pkg::GAMMA_TABLE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [hdrtm_pkg::CH_W-1:0]     red_in,
  input  logic signed [hdrtm_pkg::CH_W-1:0]     green_in,
  input  logic signed [hdrtm_pkg::CH_W-1:0]     blue_in,
  output logic                                  done,
  output logic [hdrtm_pkg::BYTE_W-1:0]          red_out,
  output logic [hdrtm_pkg::BYTE_W-1:0]          green_out,
  output logic [hdrtm_pkg::BYTE_W-1:0]          blue_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hdrtm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hdrtm_pkg::GAIN_W-1:0]          cfg_data
);

  localparam int AW = $clog2(GAMMA_TABLE_DEPTH);
  localparam int NDIV = 17;
  localparam logic [56:0] DEN_BIAS = 57'(hdrtm_pkg::K_D_ADD) << 16;

  // Configuration registers.
  logic                         tone_enable;
  logic [hdrtm_pkg::GAIN_W-1:0] exposure_gain;
  logic [hdrtm_pkg::GAIN_W-1:0] gamma_value;
  logic                         cfg_we;
  logic                         restart;
  logic                         bld_busy;
  logic                         accept;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == hdrtm_pkg::CFG_GAMMA_VALUE);
  assign busy      = rst || bld_busy;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_enable   <= hdrtm_pkg::RST_TONE_ENABLE;
      exposure_gain <= hdrtm_pkg::RST_EXPOSURE_GAIN;
      gamma_value   <= hdrtm_pkg::RST_GAMMA_VALUE;
    end else if (cfg_we) begin
      case (cfg_index)
        hdrtm_pkg::CFG_TONE_ENABLE:   tone_enable   <= cfg_data[0];
        hdrtm_pkg::CFG_EXPOSURE_GAIN: exposure_gain <= cfg_data;
        hdrtm_pkg::CFG_GAMMA_VALUE:   gamma_value   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Table sequencer and the three table copies, one per channel read port.
  logic                         tbl_we;
  logic [AW-1:0]                tbl_addr;
  logic [hdrtm_pkg::BYTE_W-1:0] tbl_data;

  hdrtm_curve_build #(
    .DEPTH (GAMMA_TABLE_DEPTH),
    .AW    (AW)
  ) u_build (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .gamma    (gamma_value),
    .busy     (bld_busy),
    .tbl_we   (tbl_we),
    .tbl_addr (tbl_addr),
    .tbl_data (tbl_data)
  );

  // Valid bits of every stage, cleared by reset.
  logic              s0_v, s1_v, s2_v, s3_v, s4_v, sm_v, si_v, rd_v;
  logic [NDIV:0]     dv_v;
  logic [NDIV:0]     qd_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      dv_v <= '0;
      sm_v <= 1'b0;
      qd_v <= '0;
      si_v <= 1'b0;
      rd_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s0_v <= accept;
      s1_v <= s0_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      dv_v <= {dv_v[NDIV-1:0], s4_v};
      sm_v <= dv_v[NDIV];
      qd_v <= {qd_v[NDIV-1:0], sm_v};
      si_v <= qd_v[NDIV];
      rd_v <= si_v;
      done <= rd_v;
    end
  end

  // Stage 0: input register.
  logic signed [hdrtm_pkg::CH_W-1:0] s0_ch [3];

  always_ff @(posedge clk) begin
    s0_ch[0] <= red_in;
    s0_ch[1] <= green_in;
    s0_ch[2] <= blue_in;
  end

  // Stage 1: peak channel, positive parts and the untoned bytes.
  logic signed [hdrtm_pkg::CH_W-1:0] pk;
  logic [16:0]       vcl [3];
  logic [25:0]       rawsum [3];
  hdrtm_pkg::ctx_t   s1_next;
  hdrtm_pkg::ctx_t   s1_ctx;

  always_comb begin
    pk = '0;
    for (int j = 0; j < 3; j++) begin
      if (s0_ch[j] > pk) pk = s0_ch[j];
    end
    s1_next.pos = pk > 24'sd0;
    s1_next.p   = s1_next.pos ? pk[22:0] : '0;
    for (int j = 0; j < 3; j++) begin
      s1_next.c[j] = (s0_ch[j] > 24'sd0) ? s0_ch[j][22:0] : '0;
      if (s0_ch[j] <= 24'sd0) begin
        vcl[j] = '0;
      end else if (s0_ch[j] >= 24'sd65536) begin
        vcl[j] = 17'd65536;
      end else begin
        vcl[j] = {1'b0, s0_ch[j][15:0]};
      end
      rawsum[j]      = {9'd0, vcl[j]} * 26'd255 + 26'd32768;
      s1_next.raw[j] = rawsum[j][23:16];
    end
  end

  always_ff @(posedge clk) begin
    s1_ctx <= s1_next;
  end

  // Stage 2: exposure. Stage 3: curve terms. Stage 4: numerator and denominator.
  logic [39:0]     e_full;
  logic [26:0]     s2_e;
  hdrtm_pkg::ctx_t s2_ctx;
  logic [44:0]     a_full, b_full;
  logic [26:0]     s3_e;
  logic [28:0]     s3_a, s3_b;
  hdrtm_pkg::ctx_t s3_ctx;
  logic [55:0]     s4_num;
  logic [56:0]     s4_den;
  hdrtm_pkg::ctx_t s4_ctx;

  assign e_full = {17'd0, s1_ctx.p} * {24'd0, exposure_gain} + 40'd2048;
  assign a_full = {18'd0, s2_e} * 45'(hdrtm_pkg::K_A_MUL);
  assign b_full = {18'd0, s2_e} * 45'(hdrtm_pkg::K_B_MUL);

  always_ff @(posedge clk) begin
    s2_e   <= e_full[38:12];
    s2_ctx <= s1_ctx;
    s3_e   <= s2_e;
    s3_a   <= a_full[44:16] + 29'(hdrtm_pkg::K_A_ADD);
    s3_b   <= b_full[44:16] + 29'(hdrtm_pkg::K_B_ADD);
    s3_ctx <= s2_ctx;
    s4_num <= {29'd0, s3_e} * {27'd0, s3_a};
    s4_den <= {30'd0, s3_e} * {28'd0, s3_b} + DEN_BIAS;
    s4_ctx <= s3_ctx;
  end

  // Curve division: seventeen restoring steps, one per stage.
  logic [56:0]     dv_rem [NDIV+1];
  logic [56:0]     dv_den [NDIV+1];
  logic [16:0]     dv_q   [NDIV+1];
  logic            dv_ge  [NDIV+1];
  hdrtm_pkg::ctx_t dv_ctx [NDIV+1];
  logic [57:0]     dv_sh  [NDIV];

  always_comb begin
    for (int s = 0; s < NDIV; s++) dv_sh[s] = {dv_rem[s], 1'b0};
  end

  always_ff @(posedge clk) begin
    dv_rem[0] <= {1'b0, s4_num};
    dv_den[0] <= s4_den;
    dv_q[0]   <= '0;
    dv_ge[0]  <= {1'b0, s4_num} >= s4_den;
    dv_ctx[0] <= s4_ctx;
    for (int s = 0; s < NDIV; s++) begin
      dv_den[s+1] <= dv_den[s];
      dv_ge[s+1]  <= dv_ge[s];
      dv_ctx[s+1] <= dv_ctx[s];
      if (dv_sh[s] >= {1'b0, dv_den[s]}) begin
        dv_rem[s+1] <= 57'(dv_sh[s] - {1'b0, dv_den[s]});
        dv_q[s+1]   <= {dv_q[s][15:0], 1'b1};
      end else begin
        dv_rem[s+1] <= dv_sh[s][56:0];
        dv_q[s+1]   <= {dv_q[s][15:0], 1'b0};
      end
    end
  end

  // Mapped peak, rounded half up to Q.16; saturates at one.
  logic [17:0]     q_inc;
  logic [16:0]     sm_m;
  hdrtm_pkg::ctx_t sm_ctx;

  assign q_inc = {1'b0, dv_q[NDIV]} + 18'd1;

  always_ff @(posedge clk) begin
    sm_m   <= dv_ge[NDIV] ? 17'd65536 : q_inc[17:1];
    sm_ctx <= dv_ctx[NDIV];
  end

  // Channel scaling by mapped/peak: three lanes of seventeen restoring steps.
  logic [39:0]     prod_n [3];
  logic [39:0]     qd_rem [NDIV+1][3];
  logic [16:0]     qd_q   [NDIV+1][3];
  hdrtm_pkg::ctx_t qd_ctx [NDIV+1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_n[j] = 40'(sm_ctx.c[j]) * 40'(sm_m) + 40'(sm_ctx.p >> 1);
    end
  end

  always_ff @(posedge clk) begin
    qd_ctx[0] <= sm_ctx;
    for (int j = 0; j < 3; j++) begin
      qd_rem[0][j] <= prod_n[j];
      qd_q[0][j]   <= '0;
    end
    for (int s = 0; s < NDIV; s++) begin
      qd_ctx[s+1] <= qd_ctx[s];
      for (int j = 0; j < 3; j++) begin
        if (qd_rem[s][j] >= (40'(qd_ctx[s].p) << (NDIV - 1 - s))) begin
          qd_rem[s+1][j] <= qd_rem[s][j] - (40'(qd_ctx[s].p) << (NDIV - 1 - s));
          qd_q[s+1][j]   <= {qd_q[s][j][15:0], 1'b1};
        end else begin
          qd_rem[s+1][j] <= qd_rem[s][j];
          qd_q[s+1][j]   <= {qd_q[s][j][15:0], 1'b0};
        end
      end
    end
  end

  // Table index: clamp to one, scale by depth minus one, round.
  logic [16:0]                  v_cl   [3];
  logic [32:0]                  idx_f  [3];
  logic [AW-1:0]                idx_c  [3];
  logic [AW-1:0]                si_idx [3];
  logic [2:0][7:0]              si_raw;
  logic [2:0][7:0]              rd_raw;
  logic [hdrtm_pkg::BYTE_W-1:0] rd_byte [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!qd_ctx[NDIV].pos) begin
        v_cl[j] = '0;
      end else if (qd_q[NDIV][j] >= 17'd65536) begin
        v_cl[j] = 17'd65536;
      end else begin
        v_cl[j] = qd_q[NDIV][j];
      end
      idx_f[j] = 33'(v_cl[j]) * 33'(GAMMA_TABLE_DEPTH - 1) + 33'd32768;
      if (idx_f[j][32:16] > 17'(GAMMA_TABLE_DEPTH - 1)) begin
        idx_c[j] = AW'(GAMMA_TABLE_DEPTH - 1);
      end else begin
        idx_c[j] = idx_f[j][AW+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) si_idx[j] <= idx_c[j];
    si_raw <= qd_ctx[NDIV].raw;
    rd_raw <= si_raw;
  end

  for (genvar j = 0; j < 3; j++) begin : g_tbl
    hdrtm_ram #(
      .WIDTH (hdrtm_pkg::BYTE_W),
      .DEPTH (GAMMA_TABLE_DEPTH),
      .AW    (AW)
    ) u_tbl (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (tbl_addr),
      .wdata (tbl_data),
      .raddr (si_idx[j]),
      .rdata (rd_byte[j])
    );
  end

  // Output register: the gamma byte when tone mapping is on, else the plain byte.
  always_ff @(posedge clk) begin
    red_out   <= tone_enable ? rd_byte[0] : rd_raw[0];
    green_out <= tone_enable ? rd_byte[1] : rd_raw[1];
    blue_out  <= tone_enable ? rd_byte[2] : rd_raw[2];
  end

  // Checks on the last division stages.
  logic [39:0] p_last;
  logic        curve_rem_ok;
  logic        scale_rem_ok;
  logic        scale_max_ok;

  assign p_last       = 40'(qd_ctx[NDIV].p);
  assign curve_rem_ok = !dv_v[NDIV] || dv_ge[NDIV] || (dv_rem[NDIV] < dv_den[NDIV]);
  assign scale_rem_ok = !qd_v[NDIV] || !qd_ctx[NDIV].pos ||
                        ((qd_rem[NDIV][0] < p_last) && (qd_rem[NDIV][1] < p_last) &&
                         (qd_rem[NDIV][2] < p_last));
  assign scale_max_ok = !qd_v[NDIV] || !qd_ctx[NDIV].pos ||
                        ((qd_q[NDIV][0] <= 17'd65536) && (qd_q[NDIV][1] <= 17'd65536) &&
                         (qd_q[NDIV][2] <= 17'd65536));

  // A gamma write always starts a fresh table pass.
  `HDRTM_ASSERT_NEXT(a_gamma_rebuild, clk, rst, restart, busy, "gamma write did not start table pass")
  // The curve remainder stays below the denominator when the curve does not saturate.
  `HDRTM_ASSERT(a_curve_rem, clk, rst, curve_rem_ok, "curve remainder out of range")
  // The scaling remainders end below the peak.
  `HDRTM_ASSERT(a_scale_rem, clk, rst, scale_rem_ok, "scale remainder out of range")
  // A scaled channel never exceeds one.
  `HDRTM_ASSERT(a_scale_max, clk, rst, scale_max_ok, "scaled channel above one")

endmodule
